[rtl/kss_pkg.sv]
// Package for the keyboard-side sync sender: codes, reset values and word types.
package kss_pkg;

   // Default ring depth.
   localparam int STORE_DEPTH = 16;

   localparam int CODE_W  = 8;
   localparam int LOW_W   = 12;
   localparam int TICKS_W = 8;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 12;

   // Reset values of the control registers.
   localparam logic [CODE_W-1:0]  INIT_CODE_RST   = 8'h80;
   localparam logic [CODE_W-1:0]  LAYOUT_CODE_RST = 8'h00;
   localparam logic [LOW_W-1:0]   SYNC_MAX_RST    = 12'd128;
   localparam logic [TICKS_W-1:0] LEAD_RST        = 8'd10;
   localparam logic [TICKS_W-1:0] START_RST       = 8'd15;
   localparam logic [TICKS_W-1:0] SHORT_RST       = 8'd15;
   localparam logic [TICKS_W-1:0] LONG_RST        = 8'd30;
   localparam logic [TICKS_W-1:0] STOP_RST        = 8'd15;

   // Register indexes on the CSR port.
   localparam logic [CSR_IDX_W-1:0] CSR_INIT_CODE   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LAYOUT_CODE = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SYNC_MAX    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_LEAD        = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_START       = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_SHORT       = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_LONG        = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_STOP        = 3'd7;

   // Command codes of an input word.
   localparam logic [1:0] CMD_TICK    = 2'd0;
   localparam logic [1:0] CMD_ENQUEUE = 2'd1;
   localparam logic [1:0] CMD_RESTART = 2'd2;

   // Index of data bit 7 in send order (fourth bit sent).
   localparam logic [2:0] LONG_BIT_SLOT = 3'd3;
   localparam logic [2:0] LAST_BIT_SLOT = 3'd7;

   typedef enum logic [2:0] {
      PH_IDLE  = 3'd0,
      PH_LOW   = 3'd1,
      PH_LEAD  = 3'd2,
      PH_START = 3'd3,
      PH_DATA  = 3'd4,
      PH_STOP  = 3'd5
   } phase_type;

   typedef struct packed {
      logic [1:0]        command;
      logic [CODE_W-1:0] key_code;
      logic              line_level;
   } req_word_type;

   typedef struct packed {
      logic line_drive_enable;
      logic line_drive_value;
      logic sending;
      logic dropped;
   } rsp_word_type;

endpackage

[rtl/keyboard_side_sync_sender.sv]
// Keyboard-side sync sender: key-code ring, low-pulse timer and bit sender.
//
// Each accepted request word is a one-microsecond tick carrying the sampled
// line level, an enqueue of a key code, or a restart, and yields exactly one
// response word describing the line drive from then on. The block takes one
// word per clock while req_stall is low: the state update is a single pass of
// short logic from the state registers into a response register, with a
// one-word skid register so a word is still taken while a finished response
// waits. req_stall rises only when both the response and skid registers are
// full. With rsp_stall low, a response is valid in the next cycle. Codes wait
// in a ring of STORE_DEPTH entries (STORE_DEPTH-1 usable); slots 0 and 1 sit
// in flops so a buffer reset reloads the init and layout codes, the rest sit
// in a RAM with registered reads fetched on the pop. No clearing pass is needed
// after reset. Configure the timing registers only while the block is idle.
module keyboard_side_sync_sender #(
   parameter int STORE_DEPTH = kss_pkg::STORE_DEPTH
) (
   input  logic                               clock,
   input  logic                               reset,
   // request channel
   input  logic                               req_valid,
   output logic                               req_stall,
   input  kss_pkg::req_word_type              req_data,
   // response channel
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output kss_pkg::rsp_word_type              rsp_data,
   // configuration writes
   input  logic                               csr_wr_en,
   input  logic [kss_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [kss_pkg::CSR_DATA_W-1:0]     csr_data
);

   localparam int PTR_W = $clog2(STORE_DEPTH);
   localparam logic [PTR_W-1:0] PTR_LAST  = PTR_W'(STORE_DEPTH - 1);
   localparam logic [PTR_W-1:0] PTR_ZERO  = '0;
   localparam logic [PTR_W-1:0] PTR_ONE   = PTR_W'(1);
   localparam logic [PTR_W-1:0] PTR_WRRST = PTR_W'(2);

   // ---------------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------------
   logic [kss_pkg::CODE_W-1:0]  init_code_ff, layout_code_ff;
   logic [kss_pkg::LOW_W-1:0]   sync_max_ff;
   logic [kss_pkg::TICKS_W-1:0] lead_ff, start_ff, short_ff, long_ff, stop_ff;

   // ---------------------------------------------------------------------
   // Sender state
   // ---------------------------------------------------------------------
   kss_pkg::phase_type          phase_ff, phase_in;
   logic [kss_pkg::LOW_W-1:0]   low_cnt_ff, low_cnt_in;
   logic [kss_pkg::TICKS_W-1:0] ph_cnt_ff, ph_cnt_in;
   logic [2:0]                  bit_idx_ff, bit_idx_in;
   logic [PTR_W-1:0]            rd_ptr_ff, rd_ptr_in;
   logic [PTR_W-1:0]            wr_ptr_ff, wr_ptr_in;

   // Ring slots 0 and 1 in flops, the rest in RAM.
   logic [kss_pkg::CODE_W-1:0]  slot0_ff, slot1_ff;
   logic [kss_pkg::CODE_W-1:0]  code_mem [STORE_DEPTH];
   logic [kss_pkg::CODE_W-1:0]  mem_rd_ff;
   logic [kss_pkg::CODE_W-1:0]  slot_code_ff;
   logic                        src_mem_ff;
   logic [kss_pkg::CODE_W-1:0]  shift_code;

   // Per-word control decoded by the next-state logic.
   logic                        do_pop;
   logic                        do_buf_reset;
   logic                        do_enqueue;
   logic                        ring_full;
   logic [PTR_W-1:0]            wr_ptr_next;

   // Handshake and response buffering.
   logic                        req_take;
   logic                        rsp_take;
   logic                        rsp_valid_ff, skid_valid_ff;
   kss_pkg::rsp_word_type       rsp_data_ff, skid_data_ff, rsp_word;

   assign req_stall = skid_valid_ff;
   assign req_take  = req_valid && !skid_valid_ff;
   assign rsp_take  = rsp_valid_ff && !rsp_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Code being sent: snapshot taken at the pop.
   assign shift_code = src_mem_ff ? mem_rd_ff : slot_code_ff;

   assign wr_ptr_next = (wr_ptr_ff == PTR_LAST) ? PTR_ZERO : wr_ptr_ff + PTR_ONE;
   assign ring_full   = (wr_ptr_next == rd_ptr_ff);

   // Length of a timed phase; zero counts as one tick.
   function automatic logic [kss_pkg::TICKS_W-1:0] fix_len(
      input logic [kss_pkg::TICKS_W-1:0] len
   );
      return (len == '0) ? kss_pkg::TICKS_W'(1) : len;
   endfunction

   // ---------------------------------------------------------------------
   // Next state
   // ---------------------------------------------------------------------
   always_comb begin
      phase_in     = phase_ff;
      low_cnt_in   = low_cnt_ff;
      ph_cnt_in    = ph_cnt_ff;
      bit_idx_in   = bit_idx_ff;
      rd_ptr_in    = rd_ptr_ff;
      wr_ptr_in    = wr_ptr_ff;
      do_pop       = 1'b0;
      do_buf_reset = 1'b0;
      do_enqueue   = 1'b0;

      unique case (req_data.command)
         kss_pkg::CMD_TICK: begin
            unique case (phase_ff)
               kss_pkg::PH_IDLE: begin
                  if (!req_data.line_level) begin
                     low_cnt_in = kss_pkg::LOW_W'(1);
                     phase_in   = kss_pkg::PH_LOW;
                  end
               end
               kss_pkg::PH_LOW: begin
                  if (!req_data.line_level) begin
                     // saturate the pulse timer
                     if (low_cnt_ff != '1) begin
                        low_cnt_in = low_cnt_ff + kss_pkg::LOW_W'(1);
                     end
                  end else begin
                     low_cnt_in = '0;
                     phase_in   = kss_pkg::PH_IDLE;
                     if (low_cnt_ff > sync_max_ff) begin
                        do_buf_reset = 1'b1;
                        rd_ptr_in    = PTR_ZERO;
                        wr_ptr_in    = PTR_WRRST;
                     end else if (rd_ptr_ff != wr_ptr_ff) begin
                        do_pop    = 1'b1;
                        rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? PTR_ZERO : rd_ptr_ff + PTR_ONE;
                        if (lead_ff == '0) begin
                           phase_in  = kss_pkg::PH_START;
                           ph_cnt_in = fix_len(start_ff);
                        end else begin
                           phase_in  = kss_pkg::PH_LEAD;
                           ph_cnt_in = lead_ff;
                        end
                     end
                  end
               end
               default: begin
                  // timed phases: count down, advance on expiry
                  if (ph_cnt_ff > 1) begin
                     ph_cnt_in = ph_cnt_ff - kss_pkg::TICKS_W'(1);
                  end else begin
                     unique case (phase_ff)
                        kss_pkg::PH_LEAD: begin
                           phase_in  = kss_pkg::PH_START;
                           ph_cnt_in = fix_len(start_ff);
                        end
                        kss_pkg::PH_START: begin
                           phase_in   = kss_pkg::PH_DATA;
                           bit_idx_in = '0;
                           ph_cnt_in  = fix_len(short_ff);
                        end
                        kss_pkg::PH_DATA: begin
                           if (bit_idx_ff == kss_pkg::LAST_BIT_SLOT) begin
                              phase_in   = kss_pkg::PH_STOP;
                              bit_idx_in = '0;
                              ph_cnt_in  = fix_len(stop_ff);
                           end else begin
                              bit_idx_in = bit_idx_ff + 3'd1;
                              ph_cnt_in  = fix_len((bit_idx_in == kss_pkg::LONG_BIT_SLOT) ?
                                                   long_ff : short_ff);
                           end
                        end
                        default: begin
                           phase_in  = kss_pkg::PH_IDLE;
                           ph_cnt_in = '0;
                        end
                     endcase
                  end
               end
            endcase
         end
         kss_pkg::CMD_ENQUEUE: begin
            if (!ring_full) begin
               do_enqueue = 1'b1;
               wr_ptr_in  = wr_ptr_next;
            end
         end
         kss_pkg::CMD_RESTART: begin
            do_buf_reset = 1'b1;
            rd_ptr_in    = PTR_ZERO;
            wr_ptr_in    = PTR_WRRST;
            phase_in     = kss_pkg::PH_IDLE;
            low_cnt_in   = '0;
            ph_cnt_in    = '0;
            bit_idx_in   = '0;
         end
         default: begin
            // unused command: hold everything
         end
      endcase
   end

   // ---------------------------------------------------------------------
   // Response word, from the state after this word
   // ---------------------------------------------------------------------
   always_comb begin
      rsp_word = '0;
      unique case (phase_in)
         kss_pkg::PH_START: begin
            rsp_word.line_drive_enable = 1'b1;
            rsp_word.sending           = 1'b1;
         end
         kss_pkg::PH_DATA: begin
            // send order 4,5,6,7,0,1,2,3; drive low for a one
            rsp_word.line_drive_enable = 1'b1;
            rsp_word.line_drive_value  = !shift_code[{~bit_idx_in[2], bit_idx_in[1:0]}];
            rsp_word.sending           = 1'b1;
         end
         kss_pkg::PH_LEAD, kss_pkg::PH_STOP: begin
            rsp_word.sending = 1'b1;
         end
         default: begin
         end
      endcase
      rsp_word.dropped = (req_data.command == kss_pkg::CMD_ENQUEUE) && ring_full;
   end

   // ---------------------------------------------------------------------
   // Control registers
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         init_code_ff   <= kss_pkg::INIT_CODE_RST;
         layout_code_ff <= kss_pkg::LAYOUT_CODE_RST;
         sync_max_ff    <= kss_pkg::SYNC_MAX_RST;
         lead_ff        <= kss_pkg::LEAD_RST;
         start_ff       <= kss_pkg::START_RST;
         short_ff       <= kss_pkg::SHORT_RST;
         long_ff        <= kss_pkg::LONG_RST;
         stop_ff        <= kss_pkg::STOP_RST;
         phase_ff       <= kss_pkg::PH_IDLE;
         low_cnt_ff     <= '0;
         ph_cnt_ff      <= '0;
         bit_idx_ff     <= '0;
         rd_ptr_ff      <= PTR_ZERO;
         wr_ptr_ff      <= PTR_WRRST;
         slot0_ff       <= kss_pkg::INIT_CODE_RST;
         slot1_ff       <= kss_pkg::LAYOUT_CODE_RST;
         src_mem_ff     <= 1'b0;
         slot_code_ff   <= '0;
         rsp_valid_ff   <= 1'b0;
         skid_valid_ff  <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            unique case (csr_index)
               kss_pkg::CSR_INIT_CODE:   init_code_ff   <= csr_data[kss_pkg::CODE_W-1:0];
               kss_pkg::CSR_LAYOUT_CODE: layout_code_ff <= csr_data[kss_pkg::CODE_W-1:0];
               kss_pkg::CSR_SYNC_MAX:    sync_max_ff    <= csr_data[kss_pkg::LOW_W-1:0];
               kss_pkg::CSR_LEAD:        lead_ff        <= csr_data[kss_pkg::TICKS_W-1:0];
               kss_pkg::CSR_START:       start_ff       <= csr_data[kss_pkg::TICKS_W-1:0];
               kss_pkg::CSR_SHORT:       short_ff       <= csr_data[kss_pkg::TICKS_W-1:0];
               kss_pkg::CSR_LONG:        long_ff        <= csr_data[kss_pkg::TICKS_W-1:0];
               kss_pkg::CSR_STOP:        stop_ff        <= csr_data[kss_pkg::TICKS_W-1:0];
               default: begin
               end
            endcase
         end

         if (req_take) begin
            phase_ff   <= phase_in;
            low_cnt_ff <= low_cnt_in;
            ph_cnt_ff  <= ph_cnt_in;
            bit_idx_ff <= bit_idx_in;
            rd_ptr_ff  <= rd_ptr_in;
            wr_ptr_ff  <= wr_ptr_in;

            // reload the two head slots on a buffer reset
            if (do_buf_reset) begin
               slot0_ff <= init_code_ff;
               slot1_ff <= layout_code_ff;
            end else if (do_enqueue && wr_ptr_ff == PTR_ZERO) begin
               slot0_ff <= req_data.key_code;
            end else if (do_enqueue && wr_ptr_ff == PTR_ONE) begin
               slot1_ff <= req_data.key_code;
            end

            // snapshot the popped code's source
            if (do_pop) begin
               src_mem_ff   <= (rd_ptr_ff > PTR_ONE);
               slot_code_ff <= (rd_ptr_ff == PTR_ONE) ? slot1_ff : slot0_ff;
            end
         end

         // response register and skid: drain in order
         if (!rsp_valid_ff || rsp_take) begin
            rsp_valid_ff  <= skid_valid_ff || req_take;
            skid_valid_ff <= 1'b0;
         end else if (req_take) begin
            skid_valid_ff <= 1'b1;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Ring RAM: one write port, one registered read port
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (req_take && do_enqueue && wr_ptr_ff > PTR_ONE) begin
         code_mem[wr_ptr_ff] <= req_data.key_code;
      end
      if (req_take && do_pop) begin
         mem_rd_ff <= code_mem[rd_ptr_ff];
      end
   end

   // Response payloads
   always_ff @(posedge clock) begin
      if (!rsp_valid_ff || rsp_take) begin
         rsp_data_ff <= skid_valid_ff ? skid_data_ff : rsp_word;
      end else if (req_take) begin
         skid_data_ff <= rsp_word;
      end
   end

endmodule

[rtl/kss_checker.sv]
// Port-level checker for the keyboard-side sync sender, bound to the top level.
module kss_checker (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_stall,
   input logic                  rsp_valid,
   input logic                  rsp_stall,
   input kss_pkg::rsp_word_type rsp_data
);

   // Drive the line only while a packet is in flight.
   a_drive_implies_sending: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.line_drive_enable |-> rsp_data.sending)
      else $error("line driven outside a packet");

   // A released line shows value zero.
   a_released_value_low: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.line_drive_enable |-> !rsp_data.line_drive_value)
      else $error("nonzero drive value while released");

   // Stall on input only when a response is waiting.
   a_stall_needs_backlog: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid)
      else $error("request stalled with no response pending");

   // Reset empties the response side.
   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("response pending after reset");

   // Hold a stalled response word.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response changed");

endmodule

bind keyboard_side_sync_sender kss_checker u_kss_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

[dv/keyboard_side_sync_sender_tb.sv]
// Testbench for the keyboard-side sync sender: opening table, then random link traffic.
`timescale 1ns / 100ps

module keyboard_side_sync_sender_tb;
   import kss_pkg::*;

   localparam int CLK_HALF = 2;
   // Command code that the block leaves unused.
   localparam logic [1:0] CMD_SPARE = 2'd3;
   localparam logic [LOW_W-1:0] LOW_CEILING = '1;
   // Response words known at a glance; field order is enable, value, sending, dropped.
   localparam rsp_word_type LINE_QUIET   = 4'b0000;
   localparam rsp_word_type DROPPED_ONLY = 4'b0001;
   // Low pulse long enough to pin the low counter at its ceiling.
   localparam int SAT_PULSE = 4100;
   // Result count at which the sink holds off, and for how long.
   localparam int PRESSURE_AT     = 500;
   localparam int PRESSURE_CYCLES = 300;
   localparam int SETTLE_CYCLES   = 8;
   localparam int DRAIN_CYCLES    = 16;
   localparam int RUN_LIMIT_NS    = 2_000_000;

   logic                  clock     = 1'b0;
   logic                  reset     = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   req_word_type          req_data  = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   rsp_word_type          rsp_data;
   logic                  csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data  = '0;

   // Mirror of the control registers.
   logic [CODE_W-1:0]  cfg_init, cfg_layout;
   logic [LOW_W-1:0]   cfg_sync;
   logic [TICKS_W-1:0] cfg_lead, cfg_start, cfg_short, cfg_long, cfg_stop;

   // Mirror of the link state.
   logic [CODE_W-1:0]  code_ring [STORE_DEPTH];
   int                 rd_ptr, wr_ptr;
   phase_type          link_phase;
   logic [LOW_W-1:0]   low_count;
   logic [TICKS_W-1:0] phase_left;
   logic [2:0]         slot;
   logic [CODE_W-1:0]  tx_code;

   rsp_word_type drive_expect_q [$];
   int           sent_count      = 0;
   int           fail_count      = 0;
   logic         steady_run      = 1'b0;
   int           abort_per_mille = 5;

   typedef struct packed {
      req_word_type word;
      logic         typed;
      rsp_word_type want;
   } table_row_type;

   table_row_type opening_rows [$];

   keyboard_side_sync_sender u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always begin
      #CLK_HALF clock = 1'b1;
      #CLK_HALF clock = 1'b0;
   end

   // ---------------------------------------------------------------
   // Link predictor
   // ---------------------------------------------------------------

   // Refill the ring with the init and layout codes.
   function automatic void ring_reload();
      code_ring[0] = cfg_init;
      code_ring[1] = cfg_layout;
      rd_ptr = 0;
      wr_ptr = 2;
   endfunction

   // Enter a timed phase; a zero length still lasts one tick.
   function automatic void enter_phase(phase_type ph, logic [TICKS_W-1:0] len);
      link_phase = ph;
      phase_left = (len == '0) ? TICKS_W'(1) : len;
   endfunction

   // Data bit 7 goes out fourth and is held long.
   function automatic logic [TICKS_W-1:0] bit_len();
      return (slot == LONG_BIT_SLOT) ? cfg_long : cfg_short;
   endfunction

   // Skip the lead wait altogether when its length is zero.
   function automatic void start_lead();
      if (cfg_lead == '0) begin
         enter_phase(PH_START, cfg_start);
      end else begin
         enter_phase(PH_LEAD, cfg_lead);
      end
   endfunction

   // Advance one microsecond with the sampled line level.
   function automatic void advance_tick(logic level);
      logic too_long;
      case (link_phase)
         PH_IDLE: begin
            if (!level) begin
               low_count  = LOW_W'(1);
               link_phase = PH_LOW;
            end
         end
         PH_LOW: begin
            if (!level) begin
               if (low_count < LOW_CEILING) low_count = low_count + 1'b1;
            end else begin
               // Host released the line: long pulse resets, short one pops a code.
               too_long   = (low_count > cfg_sync);
               low_count  = '0;
               link_phase = PH_IDLE;
               if (too_long) begin
                  ring_reload();
               end else if (rd_ptr != wr_ptr) begin
                  tx_code = code_ring[rd_ptr];
                  rd_ptr  = (rd_ptr + 1) % STORE_DEPTH;
                  start_lead();
               end
            end
         end
         default: begin
            // Line level is ignored while the block owns the line.
            if (phase_left != '0) phase_left = phase_left - 1'b1;
            if (phase_left == '0) begin
               case (link_phase)
                  PH_LEAD: enter_phase(PH_START, cfg_start);
                  PH_START: begin
                     slot = '0;
                     enter_phase(PH_DATA, bit_len());
                  end
                  PH_DATA: begin
                     if (slot >= LAST_BIT_SLOT) begin
                        slot = '0;
                        enter_phase(PH_STOP, cfg_stop);
                     end else begin
                        slot = slot + 3'd1;
                        enter_phase(PH_DATA, bit_len());
                     end
                  end
                  default: begin
                     link_phase = PH_IDLE;
                     phase_left = '0;
                  end
               endcase
            end
         end
      endcase
   endfunction

   // Apply one request word and return the drive it leaves on the line.
   function automatic rsp_word_type predict_drive(req_word_type w);
      rsp_word_type r;
      logic [2:0]   bit_no;
      int           nxt;
      r = LINE_QUIET;
      case (w.command)
         CMD_TICK: advance_tick(w.line_level);
         CMD_ENQUEUE: begin
            nxt = (wr_ptr + 1) % STORE_DEPTH;
            if (nxt == rd_ptr) begin
               r.dropped = 1'b1;
            end else begin
               code_ring[wr_ptr] = w.key_code;
               wr_ptr = nxt;
            end
         end
         CMD_RESTART: begin
            ring_reload();
            link_phase = PH_IDLE;
            low_count  = '0;
            phase_left = '0;
            slot       = '0;
         end
         default: ;
      endcase
      if (link_phase == PH_START) begin
         r.line_drive_enable = 1'b1;
         r.line_drive_value  = 1'b0;
      end else if (link_phase == PH_DATA) begin
         // Bits go out 4,5,6,7,0,1,2,3; a one pulls the line low.
         bit_no = slot + 3'd4;
         r.line_drive_enable = 1'b1;
         r.line_drive_value  = ~tx_code[bit_no];
      end
      r.sending = (link_phase >= PH_LEAD && link_phase <= PH_STOP);
      return r;
   endfunction

   // ---------------------------------------------------------------
   // Request side
   // ---------------------------------------------------------------

   function automatic req_word_type mk_word(logic [1:0] cmd, logic [CODE_W-1:0] key,
                                            logic level);
      req_word_type w;
      w.command    = cmd;
      w.key_code   = key;
      w.line_level = level;
      return w;
   endfunction

   function automatic void add_row(logic [1:0] cmd, logic [CODE_W-1:0] key, logic level,
                                   logic typed, rsp_word_type want);
      table_row_type row;
      row.word  = mk_word(cmd, key, level);
      row.typed = typed;
      row.want  = want;
      opening_rows.push_back(row);
   endfunction

   // Offer one word after a random gap (none in a steady run), hold it until taken, then log its result.
   task automatic send_word(req_word_type w, logic typed = 1'b0,
                            rsp_word_type want = LINE_QUIET);
      int           gap;
      rsp_word_type guess;
      gap = steady_run ? 0 : $urandom_range(0, 3);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= w;
      @(posedge clock);
      while (req_stall !== 1'b0) @(posedge clock);
      guess = predict_drive(w);
      drive_expect_q.push_back(typed ? want : guess);
      sent_count++;
   endtask

   // Keep ticking until the packet on the line is done, with some noise mixed in.
   task automatic ride_out();
      int roll;
      while (link_phase >= PH_LEAD && link_phase <= PH_STOP) begin
         roll = $urandom_range(0, 999);
         if (roll < abort_per_mille) begin
            send_word(mk_word(CMD_RESTART, $urandom_range(0, 255), $urandom_range(0, 1)));
         end else if (roll < 20) begin
            send_word(mk_word(CMD_ENQUEUE, $urandom_range(0, 255), $urandom_range(0, 1)));
         end else if (roll < 30) begin
            send_word(mk_word(CMD_SPARE, $urandom_range(0, 255), $urandom_range(0, 1)));
         end else begin
            send_word(mk_word(CMD_TICK, $urandom_range(0, 255), $urandom_range(0, 1)));
         end
      end
   endtask

   // One host exchange: queue codes, idle, pull low for a while, release.
   task automatic run_exchange(int pulse_len);
      int n_codes, n_idle, k, roll, span;
      steady_run = ($urandom_range(0, 4) == 0);
      ride_out();
      // Now and then flood the ring so it may overflow.
      n_codes = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 16) : $urandom_range(0, 3);
      for (k = 0; k < n_codes; k++)
         send_word(mk_word(CMD_ENQUEUE, $urandom_range(0, 255), $urandom_range(0, 1)));
      n_idle = $urandom_range(0, 4);
      for (k = 0; k < n_idle; k++)
         send_word(mk_word(CMD_TICK, $urandom_range(0, 255), 1'b1));
      if (pulse_len == 0) begin
         // Aim at the sync limit and just past it when the limit is short enough.
         span = (cfg_sync > 300 || cfg_sync == '0) ? 24 : int'(cfg_sync);
         roll = $urandom_range(0, 9);
         if (roll < 6) begin
            pulse_len = $urandom_range(1, (span < 24) ? span : 24);
         end else if (roll < 8) begin
            pulse_len = span;
         end else begin
            pulse_len = span + 1;
         end
      end
      for (k = 0; k < pulse_len; k++) begin
         roll = $urandom_range(0, 999);
         if (roll < abort_per_mille) begin
            send_word(mk_word(CMD_RESTART, $urandom_range(0, 255), $urandom_range(0, 1)));
         end else if (roll < 20) begin
            send_word(mk_word(CMD_ENQUEUE, $urandom_range(0, 255), $urandom_range(0, 1)));
         end
         send_word(mk_word(CMD_TICK, $urandom_range(0, 255), 1'b0));
      end
      send_word(mk_word(CMD_TICK, $urandom_range(0, 255), 1'b1));
   endtask

   task automatic run_random(int budget, int first_pulse);
      int start_count;
      start_count = sent_count;
      if (first_pulse > 0) run_exchange(first_pulse);
      while (sent_count - start_count < budget) run_exchange(0);
      ride_out();
   endtask

   // ---------------------------------------------------------------
   // Register writes
   // ---------------------------------------------------------------

   task automatic csr_write(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] value);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      case (idx)
         CSR_INIT_CODE:   cfg_init   = value[CODE_W-1:0];
         CSR_LAYOUT_CODE: cfg_layout = value[CODE_W-1:0];
         CSR_SYNC_MAX:    cfg_sync   = value[LOW_W-1:0];
         CSR_LEAD:        cfg_lead   = value[TICKS_W-1:0];
         CSR_START:       cfg_start  = value[TICKS_W-1:0];
         CSR_SHORT:       cfg_short  = value[TICKS_W-1:0];
         CSR_LONG:        cfg_long   = value[TICKS_W-1:0];
         CSR_STOP:        cfg_stop   = value[TICKS_W-1:0];
         default: ;
      endcase
   endtask

   // Abort any packet, drain every result, then load a full register set.
   task automatic apply_setting(logic [CSR_DATA_W-1:0] init_v, layout_v, sync_v, lead_v,
                                start_v, short_v, long_v, stop_v);
      steady_run = 1'b0;
      send_word(mk_word(CMD_RESTART, 8'h00, 1'b1));
      req_valid <= 1'b0;
      while (drive_expect_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_write(CSR_INIT_CODE,   init_v);
      csr_write(CSR_LAYOUT_CODE, layout_v);
      csr_write(CSR_SYNC_MAX,    sync_v);
      csr_write(CSR_LEAD,        lead_v);
      csr_write(CSR_START,       start_v);
      csr_write(CSR_SHORT,       short_v);
      csr_write(CSR_LONG,        long_v);
      csr_write(CSR_STOP,        stop_v);
      csr_wr_en <= 1'b0;
   endtask

   // ---------------------------------------------------------------
   // Result side
   // ---------------------------------------------------------------

   // Stall before each word at random, never in a steady run; once, hold off long enough to back up the input.
   initial begin : result_sink
      int hold;
      int taken;
      taken = 0;
      while (reset !== 1'b0) @(posedge clock);
      forever begin
         if (taken == PRESSURE_AT) begin
            hold = PRESSURE_CYCLES;
         end else if (steady_run) begin
            hold = 0;
         end else begin
            hold = $urandom_range(0, 3);
         end
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         @(posedge clock);
         while (rsp_valid !== 1'b1) @(posedge clock);
         taken++;
      end
   end

   function automatic void check_bit(string field, logic want, logic got);
      if (got !== want) begin
         $error("%s: expected %b, got %b", field, want, got);
         fail_count++;
      end
   endfunction

   // Match each taken response word against the oldest prediction.
   always @(posedge clock) begin : response_check
      rsp_word_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (drive_expect_q.size() == 0) begin
            $error("response word %b arrived with nothing expected", rsp_data);
            fail_count++;
         end else begin
            want = drive_expect_q.pop_front();
            check_bit("line_drive_enable", want.line_drive_enable, rsp_data.line_drive_enable);
            check_bit("line_drive_value", want.line_drive_value, rsp_data.line_drive_value);
            check_bit("sending", want.sending, rsp_data.sending);
            check_bit("dropped", want.dropped, rsp_data.dropped);
         end
      end
   end

   // ---------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------

   initial begin : stimulus
      // Load the register mirror and ring with their reset contents.
      cfg_init   = INIT_CODE_RST;
      cfg_layout = LAYOUT_CODE_RST;
      cfg_sync   = SYNC_MAX_RST;
      cfg_lead   = LEAD_RST;
      cfg_start  = START_RST;
      cfg_short  = SHORT_RST;
      cfg_long   = LONG_RST;
      cfg_stop   = STOP_RST;
      foreach (code_ring[i]) code_ring[i] = '0;
      ring_reload();
      link_phase = PH_IDLE;
      low_count  = '0;
      phase_left = '0;
      slot       = '0;
      tx_code    = '0;

      // Opening table, run with the reset register values.
      add_row(CMD_TICK,    8'h00, 1'b1, 1'b1, LINE_QUIET);   // fresh out of reset
      add_row(CMD_SPARE,   8'hFF, 1'b1, 1'b1, LINE_QUIET);   // unused command does nothing
      add_row(CMD_SPARE,   8'h00, 1'b0, 1'b1, LINE_QUIET);
      add_row(CMD_ENQUEUE, 8'h00, 1'b0, 1'b0, LINE_QUIET);   // fill the ring to capacity
      add_row(CMD_ENQUEUE, 8'hFF, 1'b1, 1'b0, LINE_QUIET);
      add_row(CMD_ENQUEUE, 8'h01, 1'b0, 1'b0, LINE_QUIET);
      add_row(CMD_ENQUEUE, 8'h80, 1'b1, 1'b0, LINE_QUIET);
      add_row(CMD_ENQUEUE, 8'h55, 1'b0, 1'b0, LINE_QUIET);
      add_row(CMD_ENQUEUE, 8'hAA, 1'b1, 1'b0, LINE_QUIET);
      add_row(CMD_ENQUEUE, 8'h7F, 1'b0, 1'b0, LINE_QUIET);
      add_row(CMD_ENQUEUE, 8'hFE, 1'b1, 1'b0, LINE_QUIET);
      add_row(CMD_ENQUEUE, 8'h0F, 1'b0, 1'b0, LINE_QUIET);
      add_row(CMD_ENQUEUE, 8'hF0, 1'b1, 1'b0, LINE_QUIET);
      add_row(CMD_ENQUEUE, 8'h33, 1'b0, 1'b0, LINE_QUIET);
      add_row(CMD_ENQUEUE, 8'hCC, 1'b1, 1'b0, LINE_QUIET);
      add_row(CMD_ENQUEUE, 8'h96, 1'b0, 1'b0, LINE_QUIET);
      add_row(CMD_ENQUEUE, 8'h3C, 1'b1, 1'b1, DROPPED_ONLY); // ring full: drop
      add_row(CMD_ENQUEUE, 8'hFF, 1'b0, 1'b1, DROPPED_ONLY);
      add_row(CMD_TICK,    8'h00, 1'b0, 1'b0, LINE_QUIET);   // one-tick sync pulse
      add_row(CMD_TICK,    8'h00, 1'b1, 1'b0, LINE_QUIET);   // release: pop, lead starts
      add_row(CMD_TICK,    8'hFF, 1'b1, 1'b0, LINE_QUIET);
      add_row(CMD_RESTART, 8'h00, 1'b1, 1'b1, LINE_QUIET);   // abort the packet
      add_row(CMD_TICK,    8'h00, 1'b0, 1'b0, LINE_QUIET);
      add_row(CMD_ENQUEUE, 8'h81, 1'b0, 1'b0, LINE_QUIET);   // enqueue while held low
      add_row(CMD_TICK,    8'h00, 1'b1, 1'b0, LINE_QUIET);

      // Hold reset at the start, then release it.
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      foreach (opening_rows[i])
         send_word(opening_rows[i].word, opening_rows[i].typed, opening_rows[i].want);

      run_random(300, 0);

      // Shortest timing, one-tick sync limit, no lead.
      apply_setting(12'hFF, 12'h01, 12'd1, 12'd0, 12'd1, 12'd1, 12'd1, 12'd1);
      run_random(300, 0);

      // Longest timing; pin the low counter at its ceiling and let the packet finish.
      apply_setting(12'h00, 12'hFF, 12'd4095, 12'd255, 12'd255, 12'd255, 12'd255, 12'd255);
      abort_per_mille = 0;
      run_random(300, SAT_PULSE);
      abort_per_mille = 5;

      // Zero phase lengths: the lead is skipped and every other timed phase lasts one tick.
      apply_setting(12'h5A, 12'hA5, 12'd2, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0);
      run_random(300, 0);

      // Zero sync limit: every low pulse resets the ring.
      apply_setting(12'hC3, 12'h3C, 12'd0, 12'd1, 12'd2, 12'd3, 12'd4, 12'd5);
      run_random(150, 0);

      // Random short timings.
      repeat (2) begin
         apply_setting($urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(1, 40),
                       $urandom_range(0, 6), $urandom_range(1, 6), $urandom_range(1, 6),
                       $urandom_range(1, 6), $urandom_range(1, 6));
         run_random(300, 0);
      end

      // Drop valid, wait out every result, then idle before the verdict.
      req_valid <= 1'b0;
      while (drive_expect_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   initial begin : watchdog
      #(RUN_LIMIT_NS);
      $display("simulation failed");
      $finish;
   end

endmodule
